// ===== rtl/core/dsfe_pkg.sv =====
// dsfe_pkg: shared types, constants and codes of the sample frame encoder
// no dependencies; used by every module in rtl/core

package dsfe_pkg;

	// frame formats
	localparam int FMT_QUAD   = 0;
	localparam int FMT_12BIT  = 1;
	localparam int FMT_OFFSET = 2;

	// selected frame format; any other value behaves as the quad format
	localparam int OUTPUT_FORMAT = FMT_QUAD;

	localparam int NUM_CH   = 4;
	localparam int CH_W     = $clog2(NUM_CH);
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = $clog2(2 * NUM_CH) + 2;
	localparam int QUO_BITS = 16;

	// full-scale code of the selected format
	localparam logic [QUO_BITS-1:0] CODE_SCALE =
		(OUTPUT_FORMAT == FMT_12BIT) ? 16'h0FFF : 16'hFFFF;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_ABOVE = 2'd2;
	localparam logic [1:0] ST_BELOW = 2'd3;

	typedef struct packed {
		logic signed [31:0] sample_value;
		logic [1:0]         channel;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
		logic [1:0] status;
	} out_item_t;

	// one item travelling down the long-division pipeline
	typedef struct packed {
		logic [1:0]          status;
		logic [CH_W-1:0]     channel;
		logic                neg;
		logic [32:0]         divisor;
		logic [32:0]         rem;
		logic [QUO_BITS-1:0] num_lo;
		logic [QUO_BITS-1:0] quo;
	} div_t;

endpackage

// ===== rtl/core/dsfe_front.sv =====
// dsfe_front: range lookup, checks, fraction setup and scaling multiply (four stages)
// depends on dsfe_pkg

module dsfe_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  adv,
	input  logic                                  in_valid,
	input  dsfe_pkg::in_item_t                    in_data,
	input  logic [dsfe_pkg::NUM_CH-1:0][31:0]     range_min,
	input  logic [dsfe_pkg::NUM_CH-1:0][31:0]     range_max,
	output logic                                  div_valid,
	output dsfe_pkg::div_t                        div_data
);

	logic                           v_s1, v_s2, v_s3;
	logic signed [31:0]             val_s1, lo_s1, hi_s1;
	logic [dsfe_pkg::CH_W-1:0]      ch_s1, ch_s2, ch_s3;
	logic [1:0]                     status_s2, status_s3;
	logic [31:0]                    n_s2, d_s2;
	logic [31:0]                    m_s3;
	logic [32:0]                    divisor_s3;
	logic                           neg_s3;

	logic signed [32:0]             n_full, d_full;
	logic [1:0]                     status_c;
	logic [33:0]                    two_n, d_ext, pos_diff, neg_diff;
	logic                           neg_c;
	logic [47:0]                    prod;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			div_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			div_valid <= v_s3;
		end
	end

	// stage 1: capture sample and the channel's range
	always_ff @(posedge clk) begin
		if (adv) begin
			val_s1 <= in_data.sample_value;
			ch_s1  <= in_data.channel;
			lo_s1  <= range_min[in_data.channel];
			hi_s1  <= range_max[in_data.channel];
		end
	end

	// stage 2: range checks and offsets from min
	always_comb begin
		n_full = {val_s1[31], val_s1} - {lo_s1[31], lo_s1};
		d_full = {hi_s1[31], hi_s1} - {lo_s1[31], lo_s1};
		if (lo_s1 >= hi_s1) begin
			status_c = dsfe_pkg::ST_RANGE;
		end else if (val_s1 > hi_s1) begin
			status_c = dsfe_pkg::ST_ABOVE;
		end else if (val_s1 < lo_s1) begin
			status_c = dsfe_pkg::ST_BELOW;
		end else begin
			status_c = dsfe_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2 <= status_c;
			ch_s2     <= ch_s1;
			n_s2      <= n_full[31:0];
			d_s2      <= d_full[31:0];
		end
	end

	// stage 3: numerator and divisor; offset format uses |2n-d| / 2d
	always_comb begin
		two_n    = {1'b0, n_s2, 1'b0};
		d_ext    = {2'b00, d_s2};
		pos_diff = two_n - d_ext;
		neg_diff = d_ext - two_n;
		neg_c    = two_n < d_ext;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s3 <= status_s2;
			ch_s3     <= ch_s2;
			if (dsfe_pkg::OUTPUT_FORMAT == dsfe_pkg::FMT_OFFSET) begin
				neg_s3     <= neg_c;
				m_s3       <= neg_c ? neg_diff[31:0] : pos_diff[31:0];
				divisor_s3 <= {d_s2, 1'b0};
			end else begin
				neg_s3     <= 1'b0;
				m_s3       <= n_s2;
				divisor_s3 <= {1'b0, d_s2};
			end
		end
	end

	// stage 4: scale by the full-scale code and set up the division
	assign prod = m_s3 * dsfe_pkg::CODE_SCALE;

	always_ff @(posedge clk) begin
		if (adv) begin
			div_data.status  <= status_s3;
			div_data.channel <= ch_s3;
			div_data.neg     <= neg_s3;
			div_data.divisor <= divisor_s3;
			div_data.rem     <= {1'b0, prod[47:16]};
			div_data.num_lo  <= prod[15:0];
			div_data.quo     <= '0;
		end
	end

endmodule

// ===== rtl/core/dsfe_div_stage.sv =====
// dsfe_div_stage: one restoring-division step, one quotient bit per stage
// depends on dsfe_pkg

module dsfe_div_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  dsfe_pkg::div_t   in_data,
	output logic             out_valid,
	output dsfe_pkg::div_t   out_data
);

	logic [33:0]    shifted;
	logic [33:0]    diff;
	logic           take;
	dsfe_pkg::div_t nxt;

	// shift in the next dividend bit and try to subtract the divisor
	always_comb begin
		shifted = {in_data.rem, in_data.num_lo[dsfe_pkg::QUO_BITS-1]};
		diff    = shifted - {1'b0, in_data.divisor};
		take    = shifted >= {1'b0, in_data.divisor};
		nxt        = in_data;
		nxt.rem    = take ? diff[32:0] : shifted[32:0];
		nxt.num_lo = {in_data.num_lo[dsfe_pkg::QUO_BITS-2:0], 1'b0};
		nxt.quo    = {in_data.quo[dsfe_pkg::QUO_BITS-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= nxt;
		end
	end

endmodule

// ===== rtl/core/dsfe_serializer.sv =====
// dsfe_serializer: builds the frame from the quotient and sends it one byte per item
// depends on dsfe_pkg

module dsfe_serializer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  dsfe_pkg::div_t       in_data,
	output logic                 take,
	output logic                 out_valid,
	input  logic                 out_stall,
	output dsfe_pkg::out_item_t  out_data
);

	logic [2:0][7:0] bytes_q;
	logic [1:0]      cnt_q;
	logic [1:0]      last_idx_q;
	logic [1:0]      status_q;
	logic            at_last;
	logic [15:0]     code;

	assign at_last = cnt_q == last_idx_q;
	assign take    = !out_valid || (!out_stall && at_last);

	// signed code for the offset format
	assign code = in_data.neg ? (~in_data.quo + 16'd1) : in_data.quo;

	// control: valid and byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			cnt_q     <= '0;
		end else if (take) begin
			out_valid <= in_valid;
			cnt_q     <= '0;
		end else if (!out_stall) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	// frame bytes of the next item
	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= in_data.status;
			if (in_data.status != dsfe_pkg::ST_OK) begin
				bytes_q    <= '0;
				last_idx_q <= 2'd0;
			end else if (dsfe_pkg::OUTPUT_FORMAT == dsfe_pkg::FMT_12BIT) begin
				bytes_q    <= {8'h00, code[7:0], code[15:8]};
				last_idx_q <= 2'd1;
			end else if (dsfe_pkg::OUTPUT_FORMAT == dsfe_pkg::FMT_OFFSET) begin
				bytes_q    <= {code[7:0], code[15:8], 8'h00};
				last_idx_q <= 2'd2;
			end else begin
				bytes_q    <= {code[7:0], code[15:8],
					5'b00000, in_data.channel, 1'b0};
				last_idx_q <= 2'd2;
			end
		end
	end

	assign out_data.frame_byte = bytes_q[cnt_q];
	assign out_data.last_byte  = at_last;
	assign out_data.status     = status_q;

endmodule

// ===== rtl/core/dac_sample_frame_encoder_core.sv =====
// dac_sample_frame_encoder_core: top level with range registers, pipeline and output
// depends on dsfe_pkg, dsfe_front, dsfe_div_stage, dsfe_serializer

// Each item (a Q16.16 sample and a channel) is checked against that channel's
// min/max registers and turned into a DAC frame: three bytes in the quad and
// offset formats, two in the 12-bit format, or a single error byte. The
// fraction (value-min)/(max-min) is scaled and divided exactly in a 20-stage
// pipeline (four setup stages, sixteen one-bit long-division stages) followed by
// the output register. Items enter back to back while in_stall is low;
// sustained throughput is one item per frame length, set by the single byte-wide
// output. Range registers sit at byte address 8*i (min) and 8*i+4 (max) and
// should only be written while idle.

module dac_sample_frame_encoder_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  dsfe_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output dsfe_pkg::out_item_t             out_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dsfe_pkg::ADDR_W-1:0]     paddr,
	input  logic [dsfe_pkg::DATA_W-1:0]     pwdata,
	output logic [dsfe_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);

	logic [dsfe_pkg::NUM_CH-1:0][31:0] min_q;
	logic [dsfe_pkg::NUM_CH-1:0][31:0] max_q;
	logic [dsfe_pkg::CH_W-1:0]         reg_ch;
	logic                              reg_is_max;
	logic                              pipe_adv;
	logic                              ser_take;

	dsfe_pkg::div_t div_pipe [0:dsfe_pkg::QUO_BITS];
	logic           div_v    [0:dsfe_pkg::QUO_BITS];

	// register file
	assign pready     = 1'b1;
	assign reg_ch     = paddr[dsfe_pkg::ADDR_W-1:3];
	assign reg_is_max = paddr[2];
	assign prdata     = reg_is_max ? max_q[reg_ch] : min_q[reg_ch];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			for (int i = 0; i < dsfe_pkg::NUM_CH; i++) begin
				max_q[i] <= 32'h0001_0000;
			end
		end else if (psel && penable && pwrite && pready) begin
			if (reg_is_max) begin
				max_q[reg_ch] <= pwdata;
			end else begin
				min_q[reg_ch] <= pwdata;
			end
		end
	end

	// pipeline moves whenever its tail is empty or handed to the serializer
	assign pipe_adv = !div_v[dsfe_pkg::QUO_BITS] || ser_take;
	assign in_stall = !pipe_adv;

	dsfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (pipe_adv),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.range_min (min_q),
		.range_max (max_q),
		.div_valid (div_v[0]),
		.div_data  (div_pipe[0])
	);

	// one quotient bit per stage
	for (genvar k = 0; k < dsfe_pkg::QUO_BITS; k++) begin : g_div
		dsfe_div_stage u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (pipe_adv),
			.in_valid  (div_v[k]),
			.in_data   (div_pipe[k]),
			.out_valid (div_v[k+1]),
			.out_data  (div_pipe[k+1])
		);
	end

	dsfe_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_v[dsfe_pkg::QUO_BITS]),
		.in_data   (div_pipe[dsfe_pkg::QUO_BITS]),
		.take      (ser_take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// error results are single zero bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != dsfe_pkg::ST_OK) |->
		(out_data.last_byte && out_data.frame_byte == 8'h00))
		else $error("error result is not a single zero byte");

	// a frame continues after a non-final byte is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !out_data.last_byte) |=> out_valid)
		else $error("frame cut short");

	// a held pipeline tail keeps its item
	assert property (@(posedge clk) disable iff (!arst_n)
		(div_v[dsfe_pkg::QUO_BITS] && !pipe_adv) |=>
		(div_v[dsfe_pkg::QUO_BITS] && $stable(div_pipe[dsfe_pkg::QUO_BITS])))
		else $error("pipeline tail lost while held");

endmodule
